// ----- src/hst_pkg.sv -----
`timescale 1ns / 1ps
// Package for the handle slot table: command and status codes, transfer
// payload structs and the controller/datapath interface types. No dependencies.
package hst_pkg;

  localparam int CAPACITY_DEF = 8;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] script_id;
    logic [31:0] key_handle;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot_index;
    logic [31:0] handle_out;
    logic [3:0]  occupied;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_RESP = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic chk_vld;
    logic hit;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- src/hst_ctrl.sv -----
`timescale 1ns / 1ps
// Controller for the handle slot table: accept, scan and respond sequencing.
// Depends on hst_pkg.
module hst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hst_pkg::dp_stat_t  stat,
  output hst_pkg::ctrl_cmd_t cmd
);

  hst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      hst_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = hst_pkg::S_SCAN;
        end
      end
      hst_pkg::S_SCAN: begin
        if (stat.chk_vld && (stat.hit || stat.last)) begin
          cmd.finish = 1'b1;
          state_nxt  = hst_pkg::S_RESP;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      hst_pkg::S_RESP: begin
        if (!stat.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = hst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/hst_dp.sv -----
`timescale 1ns / 1ps
// Datapath for the handle slot table: slot memory, scan pointer, compare,
// handle counter, occupancy count and output register. Depends on hst_pkg.
module hst_dp #(
  parameter int CAPACITY = hst_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hst_pkg::in_t       in_data,
  input  hst_pkg::ctrl_cmd_t cmd,
  output hst_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_stall,
  output hst_pkg::out_t      out_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = IW + 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [63:0]         slot_mem_r [CAPACITY];
  logic [CAPACITY-1:0] vld_r;

  hst_pkg::cmd_t cmd_r;
  logic [31:0]   sid_r;
  logic [31:0]   key_r;
  logic [PW-1:0] ptr_r;
  logic [IW-1:0] chk_idx_r;
  logic          chk_vld_r;
  logic [63:0]   rd_data_r;
  logic          rd_vld_r;
  logic [31:0]   ctr_r, ctr_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  hst_pkg::out_t res_r, res_nxt;
  hst_pkg::out_t out_data_r;
  logic          out_valid_r;

  logic [31:0]   cur_id;
  logic [31:0]   cur_h;
  logic [31:0]   key_sel;
  logic [31:0]   new_id;
  logic [31:0]   new_h;
  logic [31:0]   ctr_inc;
  logic          hit;
  logic          rd_go;
  logic          wr_en;
  logic [IW+2:0] idx_ext;
  logic [CW+3:0] occ_ext;

  assign rd_go = cmd.issue && (ptr_r < PW'(CAPACITY));

  always_comb begin
    cur_id  = rd_vld_r ? rd_data_r[63:32] : 32'd0;
    cur_h   = rd_vld_r ? rd_data_r[31:0] : 32'd0;
    key_sel = (cmd_r == hst_pkg::CMD_INSERT) ? 32'd0 : key_r;
    hit     = (cmd_r == hst_pkg::CMD_ADD) ? (cur_id == 32'd0) : (cur_h == key_sel);

    ctr_inc = ctr_r + 32'd1;
    ctr_nxt = ctr_r;
    new_id  = sid_r;
    new_h   = key_r;
    case (cmd_r)
      hst_pkg::CMD_ADD: begin
        new_h = (ctr_inc == 32'd0) ? 32'd1 : ctr_inc;
      end
      hst_pkg::CMD_REMOVE: begin
        new_id = 32'd0;
        new_h  = 32'd0;
      end
      default: begin
        new_h = key_r;
      end
    endcase

    wr_en   = cmd.finish && hit && (cmd_r != hst_pkg::CMD_FIND);
    occ_nxt = occ_r;
    if (wr_en) begin
      occ_nxt = occ_r + CW'(new_id != 32'd0) - CW'(cur_id != 32'd0);
      if (cmd_r == hst_pkg::CMD_ADD) begin
        ctr_nxt = new_h;
      end
    end

    idx_ext = {3'd0, chk_idx_r};
    occ_ext = {4'd0, occ_nxt};
    res_nxt = res_r;
    if (cmd.finish) begin
      if (hit) begin
        res_nxt.status     = hst_pkg::ST_OK;
        res_nxt.slot_index = idx_ext[2:0];
        res_nxt.handle_out = (cmd_r == hst_pkg::CMD_ADD) ? new_h : 32'd0;
      end else begin
        res_nxt.status     = (cmd_r inside {hst_pkg::CMD_ADD, hst_pkg::CMD_INSERT}) ?
                             hst_pkg::ST_FULL : hst_pkg::ST_NOT_FOUND;
        res_nxt.slot_index = 3'd0;
        res_nxt.handle_out = 32'd0;
      end
      res_nxt.occupied = occ_ext[3:0];
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[chk_idx_r] <= {new_id, new_h};
    end
    if (rd_go) begin
      rd_data_r <= slot_mem_r[ptr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_data.command;
      sid_r <= in_data.script_id;
      key_r <= in_data.key_handle;
      ptr_r <= '0;
    end else if (rd_go) begin
      ptr_r <= ptr_r + PW'(1);
    end
    if (rd_go) begin
      chk_idx_r <= ptr_r[IW-1:0];
      rd_vld_r  <= vld_r[ptr_r[IW-1:0]];
    end
    res_r <= res_nxt;
    if (cmd.push) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      ctr_r       <= '0;
      occ_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[chk_idx_r] <= 1'b1;
      end
      ctr_r <= ctr_nxt;
      occ_r <= occ_nxt;
      if (cmd.load) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.issue || cmd.finish) begin
        chk_vld_r <= rd_go;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.chk_vld  = chk_vld_r;
  assign stat.hit      = hit;
  assign stat.last     = (chk_idx_r == IW'(CAPACITY - 1));
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/handle_slot_table.sv -----
`timescale 1ns / 1ps
// Handle slot table, top level: controller and datapath.
// Depends on hst_pkg, hst_ctrl and hst_dp.
//
// Each command (add, remove, find, insert) scans the slot memory one slot per
// cycle from slot zero and stops at the first match, then writes back in the
// same cycle it decides. A command that matches nothing scans all CAPACITY
// slots (8 at the default); the single read port of the slot memory sets the
// scan length. One command is in flight at a time; the next is accepted while
// the previous result waits in the output register. Reset clears the table at
// once through per-slot valid bits, so there is no clearing pass.
module handle_slot_table #(
  parameter int CAPACITY = hst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hst_pkg::out_t out_data
);

  hst_pkg::ctrl_cmd_t cmd;
  hst_pkg::dp_stat_t  stat;

  hst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/handle_slot_table_tb.sv -----
`timescale 1ns / 1ps
// Testbench for handle_slot_table: a directed table of commands, then random
// add/remove/find/insert traffic in three idle/stall phases, checked against a
// slot-table predictor kept in this file. Depends on hst_pkg and handle_slot_table.
module handle_slot_table_tb;
  import hst_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic [31:0] slot_id_model [SLOTS];
  logic [31:0] slot_handle_model [SLOTS];
  logic [31:0] handle_count_model;
  out_t        expected_results [$];
  dir_row_t    dir_rows [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          error_count = 0;
  int          report_count = 0;
  int          quiet_cycles = 0;
  out_t        want;

  handle_slot_table DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int count_occupied_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_id_model[i] != 32'd0) n++;
    end
    return n;
  endfunction

  function automatic out_t predict_table_op(in_t item);
    out_t res;
    int   hit;
    int   occ;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    occ = count_occupied_slots();
    case (item.command)
      CMD_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && slot_id_model[i] == 32'd0) hit = i;
        end
        if (occ >= SLOTS || hit < 0) begin
          res.status = ST_FULL;
          hit = -1;
        end else begin
          handle_count_model = handle_count_model + 32'd1;
          if (handle_count_model == 32'd0) handle_count_model = 32'd1;
          slot_id_model[hit] = item.script_id;
          slot_handle_model[hit] = handle_count_model;
          res.handle_out = handle_count_model;
        end
      end
      CMD_REMOVE, CMD_FIND: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && slot_handle_model[i] == item.key_handle) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else if (item.command == CMD_REMOVE) begin
          slot_id_model[hit] = 32'd0;
          slot_handle_model[hit] = 32'd0;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && slot_handle_model[i] == 32'd0) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_id_model[hit] = item.script_id;
          slot_handle_model[hit] = item.key_handle;
        end
      end
    endcase
    if (hit >= 0) res.slot_index = hit[2:0];
    occ = count_occupied_slots();
    res.occupied = occ[3:0];
    return res;
  endfunction

  function automatic void push_row(cmd_t cmd, logic [31:0] sid, logic [31:0] key, bit typed,
                                   status_t st, logic [2:0] slot, logic [31:0] hdl,
                                   logic [3:0] occ);
    dir_row_t row;
    row.stim.command = cmd;
    row.stim.script_id = sid;
    row.stim.key_handle = key;
    row.typed = typed;
    row.result.status = st;
    row.result.slot_index = slot;
    row.result.handle_out = hdl;
    row.result.occupied = occ;
    dir_rows.push_back(row);
  endfunction

  // Mostly keys taken from the model's slots, so removes and finds reach deep into the table.
  function automatic in_t make_random_item();
    in_t item;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) item.command = CMD_ADD;
    else if (pick < 55) item.command = CMD_REMOVE;
    else if (pick < 80) item.command = CMD_FIND;
    else item.command = CMD_INSERT;
    pick = $urandom_range(0, 99);
    if (pick < 10) item.script_id = 32'd0;
    else if (pick < 15) item.script_id = 32'hFFFF_FFFF;
    else item.script_id = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60) item.key_handle = slot_handle_model[$urandom_range(0, SLOTS - 1)];
    else if (pick < 70) item.key_handle = 32'd0;
    else if (pick < 75) item.key_handle = 32'hFFFF_FFFF;
    else if (pick < 85) item.key_handle = handle_count_model + $urandom_range(0, 3);
    else item.key_handle = $urandom;
    return item;
  endfunction

  task automatic send_item(input in_t item, input bit typed, input out_t typed_result);
    out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_table_op(item);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_for_drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic void report_mismatch(string field, logic [31:0] exp_val,
                                          logic [31:0] act_val);
    error_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_data.status));
        if (out_data.slot_index !== want.slot_index)
          report_mismatch("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
        if (out_data.handle_out !== want.handle_out)
          report_mismatch("handle_out", want.handle_out, out_data.handle_out);
        if (out_data.occupied !== want.occupied)
          report_mismatch("occupied", 32'(want.occupied), 32'(out_data.occupied));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("handle_slot_table test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int   phase;
    in_t  item;
    out_t no_result;
    no_result = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_id_model[i] = 32'd0;
      slot_handle_model[i] = 32'd0;
    end
    handle_count_model = 32'd0;

    push_row(CMD_FIND,   32'h0000_0000, 32'h0000_0000, 1, ST_OK,        3'd0, 32'd0, 4'd0);
    push_row(CMD_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 3'd0, 32'd0, 4'd0);
    push_row(CMD_REMOVE, 32'h0000_0000, 32'h0000_0005, 1, ST_NOT_FOUND, 3'd0, 32'd0, 4'd0);
    push_row(CMD_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK,        3'd0, 32'd1, 4'd1);
    push_row(CMD_ADD,    32'h0000_0000, 32'h0000_0000, 1, ST_OK,        3'd1, 32'd2, 4'd1);
    push_row(CMD_ADD,    32'h0000_0001, 32'h0000_0000, 1, ST_OK,        3'd1, 32'd3, 4'd2);
    push_row(CMD_INSERT, 32'h1234_5678, 32'h0000_0000, 1, ST_OK,        3'd2, 32'd0, 4'd3);
    push_row(CMD_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1, ST_OK,        3'd2, 32'd0, 4'd3);
    push_row(CMD_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 1, ST_OK,        3'd2, 32'd0, 4'd3);
    push_row(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, ST_OK,        3'd3, 32'd0, 4'd3);
    push_row(CMD_ADD,    32'h5555_5555, 32'h0000_0000, 1, ST_OK,        3'd3, 32'd4, 4'd4);
    push_row(CMD_ADD,    32'h0000_0001, 32'h0000_0000, 0, ST_OK,        3'd0, 32'd0, 4'd0);
    push_row(CMD_ADD,    32'h8000_0000, 32'h0000_0000, 0, ST_OK,        3'd0, 32'd0, 4'd0);
    push_row(CMD_ADD,    32'h7FFF_FFFF, 32'h0000_0000, 0, ST_OK,        3'd0, 32'd0, 4'd0);
    push_row(CMD_ADD,    32'hDEAD_BEEF, 32'h0000_0000, 1, ST_OK,        3'd7, 32'd8, 4'd8);
    push_row(CMD_ADD,    32'h0000_0001, 32'h0000_0000, 1, ST_FULL,      3'd0, 32'd0, 4'd8);
    push_row(CMD_INSERT, 32'h0000_0002, 32'h0000_0003, 1, ST_FULL,      3'd0, 32'd0, 4'd8);
    push_row(CMD_FIND,   32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 3'd0, 32'd0, 4'd8);
    push_row(CMD_FIND,   32'h0000_0000, 32'h0000_0008, 1, ST_OK,        3'd7, 32'd0, 4'd8);
    push_row(CMD_REMOVE, 32'h0000_0000, 32'h0000_0003, 1, ST_OK,        3'd1, 32'd0, 4'd7);
    push_row(CMD_ADD,    32'h0000_0000, 32'h0000_0000, 1, ST_OK,        3'd1, 32'd9, 4'd7);
    push_row(CMD_INSERT, 32'h0000_0007, 32'h8000_0000, 1, ST_FULL,      3'd0, 32'd0, 4'd7);
    push_row(CMD_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 1, ST_OK,        3'd2, 32'd0, 4'd6);
    push_row(CMD_INSERT, 32'h0000_0000, 32'h8000_0000, 0, ST_OK,        3'd0, 32'd0, 4'd0);
    push_row(CMD_REMOVE, 32'h0000_0000, 32'h0000_0001, 1, ST_OK,        3'd0, 32'd0, 4'd5);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].result);
      end
      for (int n = 0; n < (RANDOM_ITEMS + 2) / 3; n++) begin
        item = make_random_item();
        send_item(item, 1'b0, no_result);
      end
      // hold the sender off until the table has answered everything
      in_valid <= 1'b0;
      wait_for_drain();
    end

    repeat (2 * SLOTS + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("handle_slot_table test passed");
    end else begin
      $display("handle_slot_table test failed");
    end
    $finish;
  end

endmodule
